### hdl/odd_line_interpolation_filter_unit_defines.svh
// ----------------------------------------------------------------------------
// odd line interpolation filter - assertion macros
// shared concurrent assertion forms for the filter rtl
// ----------------------------------------------------------------------------
`ifndef ODD_LINE_INTERPOLATION_FILTER_UNIT_DEFINES_SVH
`define ODD_LINE_INTERPOLATION_FILTER_UNIT_DEFINES_SVH

// same-cycle implication, masked while reset is low
`define OLIF_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("olif assertion failed");

// next-cycle implication, masked while reset is low
`define OLIF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("olif assertion failed");

`endif

### hdl/olif_pkg.sv
// ----------------------------------------------------------------------------
// olif_pkg
// sizes, result word type and helpers for the odd line interpolation filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package olif_pkg;

    localparam int MAX_COLS    = 2048;
    localparam int MAX_ROWS    = 2048;
    localparam int COL_W       = $clog2(MAX_COLS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int COLS_SIZE_W = $clog2(MAX_COLS + 1);
    localparam int ROWS_SIZE_W = $clog2(MAX_ROWS + 1);
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 4;
    localparam int PIX_W       = 8;
    localparam int OUT_IDX_W   = 11;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int M_DATA_W    = ((2 * OUT_IDX_W + PIX_W + 7) / 8) * 8;

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_COLS = CFG_IDX_W'(0),
        REG_IMAGE_ROWS = CFG_IDX_W'(1)
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] out_row;
        logic [OUT_IDX_W-1:0] out_col;
        logic [PIX_W-1:0]     value;
        logic                 last_of_run;
        logic                 last_of_frame;
    } result_t;

    // floor average of two pixels
    function automatic logic [PIX_W-1:0] avg2(input logic [PIX_W-1:0] a,
                                              input logic [PIX_W-1:0] b);
        logic [PIX_W:0] sum;
        sum  = {1'b0, a} + {1'b0, b};
        avg2 = sum[PIX_W:1];
    endfunction

endpackage

### hdl/olif_ram.sv
// ----------------------------------------------------------------------------
// olif_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module olif_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old word on a same-address collision
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hdl/odd_line_interpolation_filter_unit.sv
// ----------------------------------------------------------------------------
// odd_line_interpolation_filter_unit
// rebuilds odd rows and odd columns of a raster band by floor averaging
// ----------------------------------------------------------------------------
//
// channel   dir  handshake                contents
// s_        in   s_tvalid / s_tready      s_tdata: pixel
// m_        out  m_tvalid / m_tready      m_tdata: out_row, out_col, value
//                                         m_tlast: last_of_frame
//                                         m_tuser: last_of_run
// cfg_      in   cfg_valid / cfg_ready    cfg_index, cfg_data (image_cols, image_rows)
//
// a pixel moves through a read stage (line store read) and a compute stage
// (store write back, up to four result words into a small batch queue)
// one result word leaves per cycle while m_tready allows; a pixel of an even row or
// of the last row gives up to four words, a pending odd row pixel gives none
// result words pass from the compute stage into the batch queue, then the output register
// the line store has no reset sweep; reset clears counters and queues, sets sizes to 512
// a stalled result port fills the batch queue, then holds the compute stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "odd_line_interpolation_filter_unit_defines.svh"

module odd_line_interpolation_filter_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input pixels
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [olif_pkg::PIX_W-1:0]        s_tdata,   // [7:0] pixel
    // filtered results
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [olif_pkg::M_DATA_W-1:0]     m_tdata,   // [10:0] out_row, [21:11] out_col,
                                                         // [29:22] value, rest zero
    output logic                              m_tlast,   // last_of_frame
    output logic                              m_tuser,   // last_of_run
    // register writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [olif_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [olif_pkg::CFG_W-1:0]        cfg_data
);

    import olif_pkg::*;

    // configuration registers
    logic [CFG_W-1:0]       cfg_cols_reg;
    logic [CFG_W-1:0]       cfg_rows_reg;
    logic [COLS_SIZE_W-1:0] cols_eff;
    logic [ROWS_SIZE_W-1:0] rows_eff;

    // raster position of the next input word
    logic [COL_W-1:0] col_count_reg;
    logic [ROW_W-1:0] row_count_reg;
    logic             s_accept;
    logic             a_last_c;
    logic             a_last_r;

    // compute stage
    logic             b_valid_reg;
    logic [COL_W-1:0] b_x_reg;
    logic [ROW_W-1:0] b_y_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic             b_last_c_reg;
    logic             b_last_r_reg;
    logic             b_adv;
    logic             b_odd;
    logic             b_pair;
    logic             b_emit;
    logic             b_we;
    logic             b_hold_upd;

    // write-to-read forwarding around the line store
    logic             fwd_hit_reg;
    logic [PIX_W-1:0] fwd_data_reg;
    logic [PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] mid_prev;

    // pixel two columns back, upper stored row and current row
    logic [PIX_W-1:0] held_upper_reg;
    logic [PIX_W-1:0] held_lower_reg;

    // batch queue of result words, entry 0 leaves first
    result_t          batch_reg  [MAX_RESULTS];
    result_t          batch_next [MAX_RESULTS];
    result_t          new_batch  [MAX_RESULTS];
    logic [CNT_W-1:0] batch_cnt_reg;
    logic [CNT_W-1:0] batch_cnt_next;
    logic [CNT_W-1:0] new_cnt;
    logic             batch_pop;
    logic             batch_free;

    // output register
    result_t          out_reg;
    logic             m_tvalid_reg;
    logic             out_take;

    logic [OUT_IDX_W-1:0] r_cur;
    logic [OUT_IDX_W-1:0] r_up;
    logic [OUT_IDX_W-1:0] c_cur;
    logic [OUT_IDX_W-1:0] c_left;

    // zero acts as one, oversize saturates
    always_comb begin
        if (cfg_cols_reg == '0) begin
            cols_eff = COLS_SIZE_W'(1);
        end else if (int'(cfg_cols_reg) > MAX_COLS) begin
            cols_eff = COLS_SIZE_W'(MAX_COLS);
        end else begin
            cols_eff = COLS_SIZE_W'(cfg_cols_reg);
        end
        if (cfg_rows_reg == '0) begin
            rows_eff = ROWS_SIZE_W'(1);
        end else if (int'(cfg_rows_reg) > MAX_ROWS) begin
            rows_eff = ROWS_SIZE_W'(MAX_ROWS);
        end else begin
            rows_eff = ROWS_SIZE_W'(cfg_rows_reg);
        end
    end

    assign cfg_ready = 1'b1;

    // handshake plumbing
    assign out_take   = !m_tvalid_reg || m_tready;
    assign batch_pop  = out_take && (batch_cnt_reg != '0);
    assign batch_free = (batch_cnt_reg == '0) ||
                        ((batch_cnt_reg == CNT_W'(1)) && batch_pop);
    assign b_adv      = b_valid_reg && batch_free;
    assign s_tready   = !b_valid_reg || b_adv;
    assign s_accept   = s_tvalid && s_tready;

    assign a_last_c = (COLS_SIZE_W'(col_count_reg) + COLS_SIZE_W'(1)) >= cols_eff;
    assign a_last_r = (ROWS_SIZE_W'(row_count_reg) + ROWS_SIZE_W'(1)) >= rows_eff;

    // stored even row
    olif_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .aclk  (aclk),
        .we    (b_we),
        .waddr (b_x_reg),
        .wdata (b_pix_reg),
        .re    (s_accept),
        .raddr (col_count_reg),
        .rdata (ram_rdata)
    );

    // compute stage decode
    assign b_odd      = b_y_reg[0];
    assign b_pair     = !b_odd && (b_y_reg != '0);
    assign b_emit     = !(b_odd && !b_last_r_reg);
    assign b_we       = b_adv && !b_odd;
    assign b_hold_upd = b_adv && b_emit && !b_x_reg[0];

    assign up       = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign mid      = avg2(up, b_pix_reg);
    assign mid_prev = avg2(held_upper_reg, held_lower_reg);

    assign r_cur  = OUT_IDX_W'(b_y_reg);
    assign r_up   = OUT_IDX_W'(b_y_reg - ROW_W'(1));
    assign c_cur  = OUT_IDX_W'(b_x_reg);
    assign c_left = OUT_IDX_W'(b_x_reg - COL_W'(1));

    // results of one pixel, odd row above first, then the current row
    always_comb begin
        new_cnt = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            new_batch[i] = '0;
        end
        if (b_emit && (!b_x_reg[0] || b_last_c_reg)) begin
            if (!b_x_reg[0] && (b_x_reg >= COL_W'(2))) begin
                if (b_pair) begin
                    new_batch[new_cnt[SLOT_W-1:0]] = '{r_up, c_left, avg2(mid_prev, mid),
                                                       1'b0, 1'b0};
                    new_cnt = new_cnt + CNT_W'(1);
                    new_batch[new_cnt[SLOT_W-1:0]] = '{r_up, c_cur, mid, 1'b0, 1'b0};
                    new_cnt = new_cnt + CNT_W'(1);
                end
                new_batch[new_cnt[SLOT_W-1:0]] = '{r_cur, c_left,
                                                   avg2(held_lower_reg, b_pix_reg),
                                                   1'b0, 1'b0};
                new_cnt = new_cnt + CNT_W'(1);
            end else if (b_pair) begin
                new_batch[new_cnt[SLOT_W-1:0]] = '{r_up, c_cur, mid, 1'b0, 1'b0};
                new_cnt = new_cnt + CNT_W'(1);
            end
            // the pixel itself always closes the run
            new_batch[new_cnt[SLOT_W-1:0]] = '{r_cur, c_cur, b_pix_reg, 1'b1,
                                               b_last_c_reg && b_last_r_reg};
            new_cnt = new_cnt + CNT_W'(1);
        end
    end

    // batch queue: load on advance, otherwise shift down on pop
    always_comb begin
        batch_next     = batch_reg;
        batch_cnt_next = batch_cnt_reg;
        if (b_adv) begin
            batch_next     = new_batch;
            batch_cnt_next = new_cnt;
        end else if (batch_pop) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                batch_next[i] = batch_reg[i + 1];
            end
            batch_next[MAX_RESULTS-1] = '0;
            batch_cnt_next = batch_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_cols_reg   <= CFG_W'(512);
            cfg_rows_reg   <= CFG_W'(512);
            col_count_reg  <= '0;
            row_count_reg  <= '0;
            b_valid_reg    <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            held_upper_reg <= '0;
            held_lower_reg <= '0;
            batch_cnt_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_IMAGE_COLS: cfg_cols_reg <= cfg_data;
                    REG_IMAGE_ROWS: cfg_rows_reg <= cfg_data;
                    default: ;
                endcase
            end

            // raster counters move on each accepted word
            if (s_accept) begin
                if (a_last_c) begin
                    col_count_reg <= '0;
                    row_count_reg <= a_last_r ? '0 : row_count_reg + ROW_W'(1);
                end else begin
                    col_count_reg <= col_count_reg + COL_W'(1);
                end
                // write back leaving the compute stage this cycle is not in the ram read
                fwd_hit_reg  <= b_we && (b_x_reg == col_count_reg);
                fwd_data_reg <= b_pix_reg;
                b_x_reg      <= col_count_reg;
                b_y_reg      <= row_count_reg;
                b_pix_reg    <= s_tdata;
                b_last_c_reg <= a_last_c;
                b_last_r_reg <= a_last_r;
            end

            if (s_accept) begin
                b_valid_reg <= 1'b1;
            end else if (b_adv) begin
                b_valid_reg <= 1'b0;
            end

            if (b_hold_upd) begin
                held_upper_reg <= up;
                held_lower_reg <= b_pix_reg;
            end

            batch_reg     <= batch_next;
            batch_cnt_reg <= batch_cnt_next;

            if (out_take) begin
                m_tvalid_reg <= batch_cnt_reg != '0;
                out_reg      <= batch_reg[0];
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_DATA_W'({out_reg.value, out_reg.out_col, out_reg.out_row});
    assign m_tlast  = out_reg.last_of_frame;
    assign m_tuser  = out_reg.last_of_run;

    // batch queue never overfills
    `OLIF_ASSERT_IMPL(a_batch_bound, aclk, aresetn, 1'b1, batch_cnt_reg <= CNT_W'(MAX_RESULTS))
    // a held compute stage keeps its pixel
    `OLIF_ASSERT_NEXT(a_stage_hold, aclk, aresetn, b_valid_reg && !b_adv,
                      b_valid_reg && $stable(b_x_reg) && $stable(b_pix_reg))
    // end of band is always the end of a run
    `OLIF_ASSERT_IMPL(a_frame_run, aclk, aresetn, m_tvalid_reg && out_reg.last_of_frame,
                      out_reg.last_of_run)
    // a pending odd row pixel yields nothing on arrival
    `OLIF_ASSERT_NEXT(a_odd_silent, aclk, aresetn, b_adv && b_odd && !b_last_r_reg,
                      batch_cnt_reg == '0)

endmodule
